>>> src/pba_pkg.sv
// Shared types, codes and constants of the page bitmap allocator.
package pba_pkg;

  localparam int NUM_REGIONS_DEF      = 4;
  localparam int PAGE_NUMBER_BITS_DEF = 16;
  localparam int MAP_WORD_BITS_DEF    = 64;

  // pages examined per cycle by the map scanner
  localparam int SCAN_LANES = 8;

  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_REGION_0    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_FIRST = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_LAST  = 3'd5;

  localparam logic [2:0]  KIND_FAULTY = 3'd4;
  localparam logic [16:0] USED_MAX    = 17'h10000;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOREGION = 2'd1;
  localparam logic [1:0] ST_OCCUPIED = 2'd2;
  localparam logic [1:0] ST_PASTEND  = 2'd3;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RESERVE = 2'd1,
    OP_FREE    = 2'd2,
    OP_COUNT   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] page_addr;
    logic [16:0] page_count;
    logic [2:0]  region_kind;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_page;
    logic [16:0] used_pages;
  } rsp_t;

  // region descriptor, same bit layout as the register
  typedef struct packed {
    logic [2:0]  kind;
    logic [16:0] count;
    logic [15:0] first;
  } region_t;

  // decoded request as queued between front and back
  typedef struct packed {
    op_t         op;
    logic        zero_n;
    logic [15:0] addr;
    logic [16:0] count;
    logic [2:0]  kind;
  } cmd_t;

  // register write strobe, with the first page of the written value
  typedef struct packed {
    logic                 valid;
    logic [REG_IDX_W-1:0] index;
    logic [15:0]          first;
  } cfg_wr_t;

endpackage

>>> src/pba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pba_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/pba_front.sv
// Front end: accepts request beats, decodes them and queues them for the back end.
module pba_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pba_pkg::req_t req,
  output logic          head_valid,
  output pba_pkg::cmd_t head,
  input  logic          pop
);

  pba_pkg::cmd_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  logic          push;
  pba_pkg::cmd_t dec;

  always_comb begin
    dec.op     = pba_pkg::op_t'(req.action);
    dec.zero_n = (req.page_count == 17'd0);
    dec.addr   = req.page_addr;
    dec.count  = req.page_count;
    dec.kind   = req.region_kind;
  end

  assign req_stall  = (cnt == 2'd2);
  assign push       = req_valid && !req_stall;
  assign head_valid = (cnt != 2'd0);
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end

`ifndef SYNTHESIS
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && cnt == 2'd1) |=> cnt == 2'd2)
    else $error("queue count did not reach full");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> cnt != 2'd0)
    else $error("pop from empty queue");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> cnt == $past(cnt) - 2'd1)
    else $error("queue count did not drop on pop");
`endif

endmodule

>>> src/pba_back.sv
// Back end: region lookup, map scanning, map update and result register.
module pba_back #(
  parameter int NumRegions     = pba_pkg::NUM_REGIONS_DEF,
  parameter int PageNumberBits = pba_pkg::PAGE_NUMBER_BITS_DEF,
  parameter int MapWordBits    = pba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  pba_pkg::cmd_t    head,
  output logic             pop,
  input  pba_pkg::region_t regions [NumRegions],
  input  logic [15:0]      kernel_first,
  input  logic [15:0]      kernel_last,
  input  pba_pkg::cfg_wr_t cfg_wr,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output pba_pkg::rsp_t    rsp
);

  localparam int LogW     = $clog2(MapWordBits);
  localparam int Depth    = (1 << PageNumberBits) / MapWordBits;
  localparam int IdxW     = PageNumberBits - LogW;
  localparam int WW       = ((PageNumberBits > 17) ? PageNumberBits : 17) + 2;
  localparam int HW       = PageNumberBits + 1;
  localparam int RidxW    = (NumRegions > 1) ? $clog2(NumRegions) : 1;
  localparam int LaneCntW = $clog2(pba_pkg::SCAN_LANES + 1);
  localparam logic [WW-1:0] TotalPages = WW'(1) << PageNumberBits;
  localparam logic [WW-1:0] PageMask   = TotalPages - WW'(1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SELECT, S_REGION, S_FETCH, S_LOAD, S_SCAN,
    S_WR_FETCH, S_WRITE, S_DONE
  } state_t;

  typedef enum logic [1:0] {M_COUNT, M_CHECK, M_SEARCH} mode_t;

  state_t           state;
  mode_t            mode;
  pba_pkg::cmd_t    cmd;
  logic [RidxW-1:0] ridx;
  logic [WW-1:0]    cur;
  logic [WW-1:0]    lim;
  logic [WW-1:0]    run_start;
  logic [16:0]      run_len;
  logic [16:0]      used;
  logic [1:0]       status;
  logic [15:0]      page;
  logic [MapWordBits-1:0] wbuf;
  logic [IdxW-1:0]  wbuf_idx;
  logic [IdxW-1:0]  widx;
  logic [WW-1:0]    wlo;
  logic [WW-1:0]    whi;
  logic             set_bits;
  logic [IdxW-1:0]  clr_idx;
  logic [HW-1:0]    hint [NumRegions];

  logic [WW-1:0]    r_first [NumRegions];
  logic [WW-1:0]    r_end   [NumRegions];
  logic [WW-1:0]    addr_w;
  logic [WW-1:0]    n_w;

  logic             alloc_found;
  logic [RidxW-1:0] alloc_r;
  logic             cont_found;
  logic             cont_stop;
  logic [RidxW-1:0] cont_r;
  logic [WW-1:0]    alloc_p;

  logic             next_found;
  logic [RidxW-1:0] next_r;

  logic [LaneCntW-1:0] adv;
  logic [LaneCntW-1:0] pop_cnt;
  logic             hit;
  logic             found;
  logic [16:0]      rl;
  logic [WW-1:0]    rs;
  logic [17:0]      used_sum;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [MapWordBits-1:0] ram_wdata;
  logic [IdxW-1:0]  ram_raddr;
  logic [MapWordBits-1:0] ram_rdata;
  logic [MapWordBits-1:0] wmask;
  logic [WW-1:0]    wbase;
  logic             wlast;

  pba_ram #(.Width(MapWordBits), .Depth(Depth)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign addr_w = WW'(cmd.addr) & PageMask;
  assign n_w    = WW'(cmd.count);

  always_comb begin
    logic [WW-1:0] raw;
    for (int i = 0; i < NumRegions; i++) begin
      r_first[i] = WW'(regions[i].first) & PageMask;
      raw        = r_first[i] + WW'(regions[i].count);
      r_end[i]   = (raw > TotalPages) ? TotalPages : raw;
    end
  end

  // region lookup: first fitting region by kind, or first containing region that fits, unless a faulty one comes first
  always_comb begin
    alloc_found = 1'b0;
    alloc_r     = '0;
    cont_found  = 1'b0;
    cont_stop   = 1'b0;
    cont_r      = '0;
    for (int i = 0; i < NumRegions; i++) begin
      if (!alloc_found && regions[i].kind == cmd.kind &&
          WW'(hint[i]) + n_w <= r_end[i]) begin
        alloc_found = 1'b1;
        alloc_r     = RidxW'(i);
      end
      if (!cont_stop && addr_w >= r_first[i] && addr_w < r_end[i]) begin
        if (regions[i].kind == pba_pkg::KIND_FAULTY) begin
          cont_stop = 1'b1;
        end else if (WW'(hint[i]) + n_w <= r_end[i]) begin
          cont_stop  = 1'b1;
          cont_found = 1'b1;
          cont_r     = RidxW'(i);
        end
      end
    end
    alloc_p = WW'(hint[alloc_r]);
    // skip the kernel image
    if (alloc_p >= WW'(kernel_first) && alloc_p <= WW'(kernel_last)) begin
      alloc_p = WW'(kernel_last) + WW'(1);
    end
  end

  always_comb begin
    next_found = 1'b0;
    next_r     = '0;
    for (int i = 0; i < NumRegions; i++) begin
      if (!next_found && RidxW'(i) >= ridx && regions[i].kind == cmd.kind) begin
        next_found = 1'b1;
        next_r     = RidxW'(i);
      end
    end
  end

  // scanner: up to SCAN_LANES pages of the buffered word per cycle in S_SCAN
  always_comb begin
    logic          stop;
    logic          ok;
    logic          bit_used;
    logic [WW-1:0] q;
    adv     = '0;
    pop_cnt = '0;
    hit     = 1'b0;
    found   = 1'b0;
    rl      = run_len;
    rs      = run_start;
    stop    = 1'b0;
    for (int i = 0; i < pba_pkg::SCAN_LANES; i++) begin
      q        = cur + WW'(i);
      ok       = !stop && (q < lim) && (q[WW-1:LogW] == (WW-LogW)'(wbuf_idx));
      bit_used = wbuf[q[LogW-1:0]];
      if (ok) begin
        adv = adv + LaneCntW'(1);
        case (mode)
          M_COUNT: begin
            pop_cnt = pop_cnt + LaneCntW'(bit_used);
          end
          M_CHECK: begin
            if (bit_used) begin
              hit  = 1'b1;
              stop = 1'b1;
            end
          end
          default: begin
            if (bit_used) begin
              rl = '0;
              rs = q + WW'(1);
            end else begin
              rl = rl + 17'd1;
              if (rl == cmd.count) begin
                found = 1'b1;
                stop  = 1'b1;
              end
            end
          end
        endcase
      end
    end
    used_sum = {1'b0, used} + 18'(pop_cnt);
  end

  always_comb begin
    wbase = WW'({widx, {LogW{1'b0}}});
    for (int b = 0; b < MapWordBits; b++) begin
      wmask[b] = (wbase + WW'(b) >= wlo) && (wbase + WW'(b) < whi);
    end
    wlast = (wbase + WW'(MapWordBits) >= whi);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = widx;
    ram_wdata = set_bits ? (ram_rdata | wmask) : (ram_rdata & ~wmask);
    ram_raddr = cur[LogW +: IdxW];
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
      end
      S_WR_FETCH: ram_raddr = wlo[LogW +: IdxW];
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_raddr = widx + IdxW'(1);
      end
      default: ;
    endcase
  end

  assign pop = (state == S_IDLE) && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NumRegions; i++) begin
        hint[i] <= '0;
      end
    end else begin
      // drop the result once taken, unless a new one loads this cycle
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_wr.valid) begin
        for (int i = 0; i < NumRegions; i++) begin
          if (cfg_wr.index == pba_pkg::REG_REGION_0 + pba_pkg::REG_IDX_W'(i)) begin
            hint[i] <= HW'(WW'(cfg_wr.first) & PageMask);
          end
        end
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IdxW'(1);
          if (clr_idx == {IdxW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head_valid) begin
            cmd    <= head;
            used   <= '0;
            page   <= '0;
            status <= pba_pkg::ST_OK;
            state  <= S_SELECT;
          end
        end
        S_SELECT: begin
          case (cmd.op)
            pba_pkg::OP_ALLOC: begin
              if (cmd.zero_n || !alloc_found) begin
                status <= pba_pkg::ST_NOREGION;
                state  <= S_DONE;
              end else begin
                cur       <= alloc_p;
                run_start <= alloc_p;
                run_len   <= '0;
                lim       <= r_end[alloc_r];
                ridx      <= alloc_r;
                mode      <= M_SEARCH;
                state     <= S_FETCH;
              end
            end
            pba_pkg::OP_RESERVE, pba_pkg::OP_FREE: begin
              if ((cmd.op == pba_pkg::OP_RESERVE && cmd.zero_n) || !cont_found) begin
                status <= pba_pkg::ST_NOREGION;
                state  <= S_DONE;
              end else if (addr_w + n_w > r_end[cont_r]) begin
                status <= pba_pkg::ST_PASTEND;
                state  <= S_DONE;
              end else if (cmd.op == pba_pkg::OP_RESERVE) begin
                cur   <= addr_w;
                lim   <= addr_w + n_w;
                mode  <= M_CHECK;
                state <= S_FETCH;
              end else begin
                hint[cont_r] <= HW'(addr_w);
                page         <= addr_w[15:0];
                wlo          <= addr_w;
                whi          <= addr_w + n_w;
                set_bits     <= 1'b0;
                state        <= cmd.zero_n ? S_DONE : S_WR_FETCH;
              end
            end
            default: begin
              ridx  <= '0;
              mode  <= M_COUNT;
              state <= S_REGION;
            end
          endcase
        end
        S_REGION: begin
          if (next_found) begin
            ridx  <= next_r;
            cur   <= r_first[next_r];
            lim   <= r_end[next_r];
            state <= S_FETCH;
          end else begin
            state <= S_DONE;
          end
        end
        S_FETCH: begin
          wbuf_idx <= cur[LogW +: IdxW];
          state    <= S_LOAD;
        end
        S_LOAD: begin
          wbuf  <= ram_rdata;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (cur >= lim) begin
            case (mode)
              M_COUNT: begin
                if (ridx == RidxW'(NumRegions - 1)) begin
                  state <= S_DONE;
                end else begin
                  ridx  <= ridx + RidxW'(1);
                  state <= S_REGION;
                end
              end
              M_CHECK: begin
                page     <= addr_w[15:0];
                wlo      <= addr_w;
                whi      <= addr_w + n_w;
                set_bits <= 1'b1;
                state    <= S_WR_FETCH;
              end
              default: begin
                status <= pba_pkg::ST_OCCUPIED;
                state  <= S_DONE;
              end
            endcase
          end else if (cur[WW-1:LogW] != (WW-LogW)'(wbuf_idx)) begin
            state <= S_FETCH;
          end else begin
            cur <= cur + WW'(adv);
            case (mode)
              M_COUNT: begin
                used <= (used_sum > 18'(pba_pkg::USED_MAX)) ?
                        pba_pkg::USED_MAX : used_sum[16:0];
              end
              M_CHECK: begin
                if (hit) begin
                  status <= pba_pkg::ST_OCCUPIED;
                  state  <= S_DONE;
                end
              end
              default: begin
                run_len   <= rl;
                run_start <= rs;
                if (found) begin
                  page       <= rs[15:0];
                  hint[ridx] <= HW'(rs + n_w);
                  wlo        <= rs;
                  whi        <= rs + n_w;
                  set_bits   <= 1'b1;
                  state      <= S_WR_FETCH;
                end
              end
            endcase
          end
        end
        S_WR_FETCH: begin
          widx  <= wlo[LogW +: IdxW];
          state <= S_WRITE;
        end
        S_WRITE: begin
          widx <= widx + IdxW'(1);
          if (wlast) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.status      <= status;
            rsp.result_page <= page;
            rsp.used_pages  <= used;
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_run_short: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && mode == M_SEARCH) |-> run_len < cmd.count)
    else $error("free run reached request length without a grant");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!rsp_valid || !rsp_stall)) |=> rsp_valid)
    else $error("finished item produced no result beat");
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> whi > wlo)
    else $error("map write pass over an empty run");
`endif

endmodule

>>> src/page_bitmap_allocator.sv
// Top level of the page bitmap allocator: register port, front end and back end.
//
//   channel  | handshake                     | beat
//   req      | req_valid in, req_stall out   | pba_pkg::req_t (action, page, count, kind)
//   rsp      | rsp_valid out, rsp_stall in   | pba_pkg::rsp_t (status, page, used)
//   register | psel/penable/pwrite, pready=1 | 64-bit data, register i at byte 8*i
//
// After reset a clearing pass zeroes the map, one word a cycle (1024 words by
// default); requests wait in the queue meanwhile, register writes go through.
// An item passes through take, select and result; per map word scanned it adds a
// fetch and load before the scan, which covers up to 8 pages a cycle; a map update
// adds a write fetch and then one write per map word. The single map read port sets
// these steps. Count scans each region of the kind in turn, with a region step each.
// A stalled result holds in the output register while two more items queue.
module page_bitmap_allocator #(
  parameter int NumRegions     = pba_pkg::NUM_REGIONS_DEF,
  parameter int PageNumberBits = pba_pkg::PAGE_NUMBER_BITS_DEF,
  parameter int MapWordBits    = pba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  pba_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output pba_pkg::rsp_t                  rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pba_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pba_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pba_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  pba_pkg::region_t regions [NumRegions];
  logic [15:0]      kernel_first;
  logic [15:0]      kernel_last;
  pba_pkg::cfg_wr_t cfg_wr;
  logic [pba_pkg::REG_IDX_W-1:0] reg_idx;
  logic             head_valid;
  pba_pkg::cmd_t    head;
  logic             pop;

  assign pready       = 1'b1;
  assign reg_idx      = paddr[pba_pkg::APB_ADDR_W-1:3];
  assign cfg_wr.valid = psel && penable && pwrite;
  assign cfg_wr.index = reg_idx;
  assign cfg_wr.first = pwdata[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_first <= '0;
      kernel_last  <= '0;
      for (int i = 0; i < NumRegions; i++) begin
        regions[i] <= '0;
      end
    end else if (cfg_wr.valid) begin
      for (int i = 0; i < NumRegions; i++) begin
        if (reg_idx == pba_pkg::REG_REGION_0 + pba_pkg::REG_IDX_W'(i)) begin
          regions[i] <= pba_pkg::region_t'(pwdata[35:0]);
        end
      end
      case (reg_idx)
        pba_pkg::REG_KERNEL_FIRST: kernel_first <= pwdata[15:0];
        pba_pkg::REG_KERNEL_LAST:  kernel_last  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < NumRegions; i++) begin
      if (reg_idx == pba_pkg::REG_REGION_0 + pba_pkg::REG_IDX_W'(i)) begin
        prdata = pba_pkg::APB_DATA_W'(regions[i]);
      end
    end
    case (reg_idx)
      pba_pkg::REG_KERNEL_FIRST: prdata = pba_pkg::APB_DATA_W'(kernel_first);
      pba_pkg::REG_KERNEL_LAST:  prdata = pba_pkg::APB_DATA_W'(kernel_last);
      default: ;
    endcase
  end

  pba_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  pba_back #(
    .NumRegions     (NumRegions),
    .PageNumberBits (PageNumberBits),
    .MapWordBits    (MapWordBits)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .regions      (regions),
    .kernel_first (kernel_first),
    .kernel_last  (kernel_last),
    .cfg_wr       (cfg_wr),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp)
  );

endmodule

>>> tb/pba_checker.sv
// Checker for the page bitmap allocator: predicts each response and compares it.
module pba_checker
  import pba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  req_t                  req,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  rsp_t                  rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOTAL = 65536;

  bit          page_used [TOTAL];
  logic [16:0] hint [NUM_REGIONS_DEF];
  region_t     region [NUM_REGIONS_DEF];
  logic [15:0] kern_first, kern_last;
  rsp_t        expected_rsp [$];

  // mid-cycle snapshots, committed at the next rising edge
  logic        req_beat, rsp_beat, reg_beat;
  req_t        req_s;
  rsp_t        rsp_s;
  logic [APB_ADDR_W-1:0] addr_s;
  logic [APB_DATA_W-1:0] data_s;

  function automatic int unsigned region_end(int i);
    int unsigned e;
    e = region[i].first + region[i].count;
    return (e > TOTAL) ? TOTAL : e;
  endfunction

  // region for reserve/free: index, -1 none, -2 faulty container
  function automatic int pick_container(int unsigned a, int unsigned n);
    for (int i = 0; i < NUM_REGIONS_DEF; i++) begin
      if (a >= region[i].first && a < region_end(i)) begin
        if (region[i].kind == KIND_FAULTY) return -2;
        if (hint[i] + n > region_end(i)) continue;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic rsp_t predict_alloc(req_t r);
    rsp_t        o;
    int          sel;
    int unsigned n, p, k, e;
    bit          found;
    o = '0;
    sel = -1;
    found = 0;
    n = r.page_count;
    if (n != 0) begin
      for (int i = 0; i < NUM_REGIONS_DEF; i++) begin
        if (region[i].kind == r.region_kind && hint[i] + n <= region_end(i)) begin
          sel = i;
          break;
        end
      end
    end
    if (sel < 0) begin
      o.status = ST_NOREGION;
      return o;
    end
    e = region_end(sel);
    p = hint[sel];
    if (p >= kern_first && p <= kern_last) p = kern_last + 1;
    while (p + n <= e) begin
      k = 0;
      while (k < n && !page_used[p+k]) k++;
      if (k == n) begin
        found = 1;
        break;
      end
      p = p + k + 1;
    end
    if (!found) begin
      o.status = ST_OCCUPIED;
    end else begin
      for (int unsigned j = 0; j < n; j++) page_used[p+j] = 1;
      hint[sel] = p + n;
      o.status = ST_OK;
      o.result_page = p[15:0];
    end
    return o;
  endfunction

  function automatic rsp_t predict_grant(req_t r);
    rsp_t        o;
    int          sel;
    int unsigned a, n, k;
    o = '0;
    a = r.page_addr;
    n = r.page_count;
    sel = (r.action == OP_RESERVE && n == 0) ? -1 : pick_container(a, n);
    if (sel < 0) begin
      o.status = ST_NOREGION;
    end else if (a + n > region_end(sel)) begin
      o.status = ST_PASTEND;
    end else if (r.action == OP_RESERVE) begin
      k = 0;
      while (k < n && !page_used[a+k]) k++;
      if (k < n) begin
        o.status = ST_OCCUPIED;
      end else begin
        for (int unsigned j = 0; j < n; j++) page_used[a+j] = 1;
        o.status = ST_OK;
        o.result_page = a[15:0];
      end
    end else begin
      for (int unsigned j = 0; j < n; j++) page_used[a+j] = 0;
      hint[sel] = a;
      o.status = ST_OK;
      o.result_page = a[15:0];
    end
    return o;
  endfunction

  function automatic rsp_t predict_count(req_t r);
    rsp_t        o;
    int unsigned used;
    o = '0;
    used = 0;
    for (int i = 0; i < NUM_REGIONS_DEF; i++) begin
      if (region[i].kind != r.region_kind) continue;
      for (int unsigned p = region[i].first; p < region_end(i); p++)
        if (page_used[p] && used < USED_MAX) used++;
    end
    o.status = ST_OK;
    o.used_pages = used[16:0];
    return o;
  endfunction

  always @(negedge clk) begin
    req_beat = req_valid && !req_stall;
    rsp_beat = rsp_valid && !rsp_stall;
    reg_beat = psel && penable && pwrite && pready;
    req_s = req;
    rsp_s = rsp;
    addr_s = paddr;
    data_s = pwdata;
  end

  always @(posedge clk) begin
    rsp_t        want;
    int unsigned idx;
    if (rst) begin
      foreach (page_used[p]) page_used[p] = 0;
      foreach (hint[i]) begin
        hint[i] = '0;
        region[i] = '0;
      end
      kern_first = '0;
      kern_last = '0;
      expected_rsp.delete();
      errors = 0;
      req_beat = 0;
      rsp_beat = 0;
      reg_beat = 0;
    end else begin
      if (reg_beat) begin
        idx = addr_s >> 3;
        if (idx < NUM_REGIONS_DEF) begin
          region[idx] = data_s[35:0];
          hint[idx] = {1'b0, region[idx].first};
        end else if (idx == REG_KERNEL_FIRST) begin
          kern_first = data_s[15:0];
        end else if (idx == REG_KERNEL_LAST) begin
          kern_last = data_s[15:0];
        end
      end
      if (req_beat) begin
        case (op_t'(req_s.action))
          OP_ALLOC:   want = predict_alloc(req_s);
          OP_COUNT:   want = predict_count(req_s);
          default:    want = predict_grant(req_s);
        endcase
        expected_rsp.push_back(want);
      end
      if (rsp_beat) begin
        if (expected_rsp.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected response %p", rsp_s);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_s.status !== want.status || rsp_s.result_page !== want.result_page ||
              rsp_s.used_pages !== want.used_pages) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected status %0d page %0d used %0d, got %0d %0d %0d",
                       want.status, want.result_page, want.used_pages,
                       rsp_s.status, rsp_s.result_page, rsp_s.used_pages);
          end
        end
      end
    end
    pending = expected_rsp.size();
  end

endmodule

>>> tb/tb.sv
// Top of the page bitmap allocator testbench: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pba_pkg::*;

  localparam int LIMIT = 3000000;

  logic                  clk, rst;
  logic                  req_valid, req_stall, rsp_valid, rsp_stall;
  req_t                  req;
  rsp_t                  rsp;
  logic                  psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;
  int                    errors, pending;
  int                    cycles;

  int          idle_pct, stall_pct;
  bit          hold_go;
  int          hold_left;
  bit          hold_done;
  logic [15:0] cfg_first [NUM_REGIONS_DEF];
  logic [16:0] cfg_cnt [NUM_REGIONS_DEF];
  logic [2:0]  cfg_kind [NUM_REGIONS_DEF];

  page_bitmap_allocator u_top (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pba_checker u_chk (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  initial clk = 0;
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off when asked
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = 400;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic reg_write(int idx, logic [63:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= APB_ADDR_W'(idx * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_region(int i, logic [15:0] first, logic [16:0] cnt, logic [2:0] kind);
    region_t d;
    d.first = first;
    d.count = cnt;
    d.kind = kind;
    cfg_first[i] = first;
    cfg_cnt[i] = cnt;
    cfg_kind[i] = kind;
    reg_write(REG_REGION_0 + i, {28'h0, d});
  endtask

  task automatic set_kernel(logic [15:0] kf, logic [15:0] kl);
    reg_write(REG_KERNEL_FIRST, {48'h0, kf});
    reg_write(REG_KERNEL_LAST, {48'h0, kl});
  endtask

  // drop valid, then wait until every accepted beat has its answer
  task automatic drain;
    req_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send(op_t op, int unsigned addr, int unsigned cnt, int unsigned kind);
    req_t r;
    bit   ok;
    r.action = op;
    r.page_addr = addr[15:0];
    r.page_count = cnt[16:0];
    r.region_kind = kind[2:0];
    req <= r;
    req_valid <= 1;
    forever begin
      @(negedge clk);
      ok = !req_stall;
      @(posedge clk);
      if (ok) break;
    end
    if ($urandom_range(99) < idle_pct) begin
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic random_config;
    int unsigned m;
    for (int i = 0; i < NUM_REGIONS_DEF; i++) begin
      if ($urandom_range(11) == 0)
        set_region(i, 16'hff00 + $urandom_range(255), 17'h1ffff, $urandom_range(0, 4));
      else
        set_region(i, $urandom_range(4095), ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 600),
                   ($urandom_range(5) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
    end
    m = $urandom_range(7);
    if (m == 0) set_kernel(16'h0000, 16'hffff);
    else if (m < 3) set_kernel(16'h0800, 16'h07ff);
    else begin
      m = $urandom_range(4095);
      set_kernel(m, m + $urandom_range(40));
    end
  endtask

  task automatic random_item;
    int unsigned sel, i, a;
    sel = $urandom_range(99);
    i = $urandom_range(NUM_REGIONS_DEF - 1);
    a = cfg_first[i] + $urandom_range(cfg_cnt[i] > 600 ? 300 : cfg_cnt[i] + 8);
    if (sel < 40)
      send(OP_ALLOC, $urandom_range(16'hffff),
           ($urandom_range(19) == 0) ? $urandom_range(17'h1ffff) : $urandom_range(1, 12),
           ($urandom_range(9) == 0) ? $urandom_range(7) : cfg_kind[i]);
    else if (sel < 65)
      send(OP_RESERVE, a, $urandom_range(1, 12), $urandom_range(7));
    else if (sel < 88)
      send(OP_FREE, a, $urandom_range(0, 12), $urandom_range(7));
    else if (sel < 95)
      send(OP_COUNT, $urandom_range(16'hffff), $urandom_range(17'h1ffff),
           ($urandom_range(3) == 0) ? $urandom_range(7) : cfg_kind[i]);
    else
      send(op_t'($urandom_range(3)), $urandom_range(16'hffff), $urandom_range(4095),
           $urandom_range(7));
  endtask

  initial begin
    int idle_tab [4] = '{0, 63, 0, 26};
    int stall_tab [4] = '{0, 0, 63, 26};
    rst = 1;
    req_valid = 0;
    req = '0;
    rsp_stall = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 0;
    hold_left = 0;
    hold_done = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: overlap, faulty container, unlisted kind, kernel skip
    set_region(0, 16'h0100, 512, 0);
    set_region(1, 16'h0200, 256, 1);
    set_region(2, 16'h0400, 128, KIND_FAULTY);
    set_region(3, 16'h0480, 64, 5);
    set_kernel(16'h0100, 16'h010f);
    send(OP_ALLOC, 0, 4, 0);
    send(OP_ALLOC, 16'hffff, 0, 0);
    send(OP_RESERVE, 16'h0120, 0, 0);
    send(OP_RESERVE, 16'h0118, 8, 0);
    send(OP_ALLOC, 0, 16, 0);
    send(OP_RESERVE, 16'h0118, 2, 0);
    send(OP_RESERVE, 16'h02fc, 8, 0);
    send(OP_RESERVE, 16'h0410, 2, 0);
    send(OP_FREE, 16'h0410, 1, 0);
    send(OP_FREE, 16'hffff, 1, 0);
    send(OP_ALLOC, 0, 64, 5);
    send(OP_ALLOC, 0, 1, 5);
    send(OP_ALLOC, 0, 1, 7);
    send(OP_FREE, 16'h0118, 0, 0);
    send(OP_FREE, 16'h0110, 4, 0);
    send(OP_ALLOC, 0, 2, 1);
    send(OP_COUNT, 0, 0, 0);
    send(OP_COUNT, 16'hffff, 17'h1ffff, 5);
    send(OP_COUNT, 0, 0, 7);
    drain;
    set_kernel(16'h0200, 16'h01ff);
    send(OP_ALLOC, 0, 3, 0);
    send(OP_ALLOC, 0, 17'h1ffff, 0);
    drain;

    // whole map: full claim, saturating count over overlapping regions
    set_region(0, 16'h0000, 17'h10000, 0);
    set_region(1, 16'h0000, 17'h10000, 0);
    set_region(2, 16'hffff, 17'h1ffff, 6);
    set_region(3, 16'h0000, 0, 3);
    set_kernel(16'hffff, 16'hffff);
    send(OP_ALLOC, 0, 17'h10000, 0);
    send(OP_COUNT, 0, 0, 0);
    send(OP_FREE, 16'h0000, 17'h10000, 0);
    send(OP_RESERVE, 16'hffff, 1, 0);
    send(OP_COUNT, 0, 0, 6);
    send(OP_FREE, 16'hffff, 1, 0);
    drain;

    for (int ph = 0; ph < 8; ph++) begin
      random_config;
      idle_pct = idle_tab[ph % 4];
      stall_pct = stall_tab[ph % 4];
      if (ph == 0) hold_go = 1;
      for (int k = 0; k < 240; k++) random_item;
      req_valid <= 0;
      drain;
    end

    idle_pct = 0;
    stall_pct = 0;
    drain;
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> files.f
src/pba_pkg.sv
src/pba_ram.sv
src/pba_front.sv
src/pba_back.sv
src/page_bitmap_allocator.sv
tb/pba_checker.sv
tb/tb.sv
